// ----- rtl/lmax3_pkg.sv -----
// lmax3_pkg: shared constants and types for the 3x3 local maximum detector
// no dependencies; used by the channel interfaces and the top level
package lmax3_pkg;

	// frame and pixel geometry
	localparam int MAX_WIDTH  = 128;
	localparam int MAX_HEIGHT = 128;
	localparam int PIXEL_BITS = 16;

	// derived widths
	localparam int COL_BITS = $clog2(MAX_WIDTH);
	localparam int ROW_BITS = $clog2(MAX_HEIGHT);
	localparam int W_BITS   = COL_BITS + 1;
	localparam int H_BITS   = ROW_BITS + 1;

	// configuration port
	localparam int CFG_BITS  = 8;
	localparam int ADDR_BITS = 3;
	localparam int DATA_BITS = 32;

	// register indexes, taken from paddr[ADDR_BITS-1]
	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	// item opcodes
	localparam logic OP_PIXEL = 1'b0;
	localparam logic OP_FLUSH = 1'b1;

	// frame border flags of the pixel being decided
	typedef struct packed {
		logic top;
		logic bot;
		logic left;
		logic right;
	} border_t;

	// one verdict
	typedef struct packed {
		logic signed [PIXEL_BITS-1:0] center_value;
		logic [ROW_BITS-1:0]          center_row;
		logic [COL_BITS-1:0]          center_col;
		logic                         is_local_max;
		logic                         frame_done;
	} res_t;

endpackage

// ----- rtl/lmax3_in_if.sv -----
// lmax3_in_if: input item channel of the 3x3 local maximum detector
// depends on lmax3_pkg
interface lmax3_in_if;
	logic                                   valid;
	logic                                   ready;
	logic                                   opcode;
	logic signed [lmax3_pkg::PIXEL_BITS-1:0] pixel;

	modport source (output valid, output opcode, output pixel, input ready);
	modport sink (input valid, input opcode, input pixel, output ready);
endinterface

// ----- rtl/lmax3_out_if.sv -----
// lmax3_out_if: verdict channel of the 3x3 local maximum detector
// depends on lmax3_pkg
interface lmax3_out_if;
	logic                                   valid;
	logic                                   ready;
	logic signed [lmax3_pkg::PIXEL_BITS-1:0] center_value;
	logic [lmax3_pkg::ROW_BITS-1:0]          center_row;
	logic [lmax3_pkg::COL_BITS-1:0]          center_col;
	logic                                   is_local_max;
	logic                                   frame_done;

	modport source (output valid, output center_value, output center_row,
		output center_col, output is_local_max, output frame_done, input ready);
	modport sink (input valid, input center_value, input center_row,
		input center_col, input is_local_max, input frame_done, output ready);
endinterface

// ----- rtl/local_maximum_3x3_top.sv -----
// Streaming 3x3 strict local maximum detector. Takes one item per clock, back to back:
// the two line stores sit in one line memory (both rows in one word, one entry per
// column) that is read when an item is accepted and written back in the next cycle, with
// forwarding when the next item hits the same column (frame width 1). A verdict for a
// pixel is produced when the item one row and one column later is accepted and passes
// through the stage 1 registers and a two-entry output queue before it is valid on the output; the
// input stalls only when that queue cannot take the verdict in flight. After a frame,
// send frame_width+1 flush items to drain the last verdicts. Registers: frame_width at
// byte address 0, frame_height at 4; write them only while the block is idle.
// depends on lmax3_pkg, lmax3_in_if, lmax3_out_if
module local_maximum_3x3_top (
	input  logic                               clk,
	input  logic                               arst_n,
	lmax3_in_if.sink                           pix,
	lmax3_out_if.source                        res,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [lmax3_pkg::ADDR_BITS-1:0]    paddr,
	input  logic [lmax3_pkg::DATA_BITS-1:0]    pwdata,
	output logic [lmax3_pkg::DATA_BITS-1:0]    prdata,
	output logic                               pready
);

	localparam int P  = lmax3_pkg::PIXEL_BITS;
	localparam int CB = lmax3_pkg::COL_BITS;
	localparam int RB = lmax3_pkg::ROW_BITS;
	localparam int WB = lmax3_pkg::W_BITS;
	localparam int HB = lmax3_pkg::H_BITS;
	localparam int CF = lmax3_pkg::CFG_BITS;

	// configuration registers
	logic [CF-1:0] fw_q, fh_q;
	logic          cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q <= CF'(lmax3_pkg::MAX_WIDTH);
			fh_q <= CF'(lmax3_pkg::MAX_HEIGHT);
		end else if (cfg_wr) begin
			case (paddr[lmax3_pkg::ADDR_BITS-1])
				lmax3_pkg::REG_WIDTH:  fw_q <= pwdata[CF-1:0];
				lmax3_pkg::REG_HEIGHT: fh_q <= pwdata[CF-1:0];
				default: ;
			endcase
		end
	end

	// register readback
	always_comb begin
		case (paddr[lmax3_pkg::ADDR_BITS-1])
			lmax3_pkg::REG_WIDTH:  prdata = lmax3_pkg::DATA_BITS'(fw_q);
			lmax3_pkg::REG_HEIGHT: prdata = lmax3_pkg::DATA_BITS'(fh_q);
			default:               prdata = '0;
		endcase
	end

	// effective frame size, clamped into 1..max
	logic [WB-1:0] eff_w;
	logic [HB-1:0] eff_h;

	always_comb begin
		if (fw_q == '0)
			eff_w = WB'(1);
		else if (32'(fw_q) > 32'(lmax3_pkg::MAX_WIDTH))
			eff_w = WB'(lmax3_pkg::MAX_WIDTH);
		else
			eff_w = WB'(fw_q);
		if (fh_q == '0)
			eff_h = HB'(1);
		else if (32'(fh_q) > 32'(lmax3_pkg::MAX_HEIGHT))
			eff_h = HB'(lmax3_pkg::MAX_HEIGHT);
		else
			eff_h = HB'(fh_q);
	end

	// position counters, updated at acceptance and cleared by any register write
	logic [CB-1:0] in_col_q, out_col_q;
	logic [RB-1:0] out_row_q;
	logic [WB-1:0] warm_q;

	logic                  acc, push, pop;
	logic [CB-1:0]         c0, in_col_nxt;
	logic [WB-1:0]         c0_inc;
	logic                  warming, last0;
	lmax3_pkg::border_t    brd0;
	logic signed [P-1:0]   v0;

	assign acc = pix.valid & pix.ready;

	always_comb begin
		c0         = ({1'b0, in_col_q} >= eff_w) ? '0 : in_col_q;
		c0_inc     = {1'b0, c0} + WB'(1);
		in_col_nxt = (c0_inc >= eff_w) ? '0 : c0_inc[CB-1:0];
		warming    = {1'b0, warm_q} < ({1'b0, eff_w} + (WB+1)'(1));
		brd0.top   = (out_row_q == '0);
		brd0.bot   = ({1'b0, out_row_q} + HB'(1)) >= eff_h;
		brd0.left  = (out_col_q == '0);
		brd0.right = ({1'b0, out_col_q} + WB'(1)) >= eff_w;
		last0      = brd0.bot & brd0.right;
		v0         = (pix.opcode == lmax3_pkg::OP_FLUSH) ? '0 : pix.pixel;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
			warm_q    <= '0;
		end else if (cfg_wr) begin
			in_col_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
			warm_q    <= '0;
		end else if (acc) begin
			in_col_q <= in_col_nxt;
			if (warming) begin
				warm_q <= warm_q + WB'(1);
			end else if (last0) begin
				in_col_q  <= '0;
				out_col_q <= '0;
				out_row_q <= '0;
				warm_q    <= '0;
			end else if (brd0.right) begin
				out_col_q <= '0;
				out_row_q <= out_row_q + RB'(1);
			end else begin
				out_col_q <= out_col_q + CB'(1);
			end
		end
	end

	// stage 1 control
	logic                  s1_valid_q;
	logic [CB-1:0]         c_s1;
	logic signed [P-1:0]   v_s1;
	logic                  emit_s1, last_s1, fwd_s1, vld_s1;
	lmax3_pkg::border_t    brd_s1;
	logic [RB-1:0]         row_s1;
	logic [CB-1:0]         col_s1;
	logic [2*P-1:0]        fwd_data_s1, rdata_s1, wdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			s1_valid_q <= 1'b0;
		else
			s1_valid_q <= acc;
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			c_s1        <= c0;
			v_s1        <= v0;
			emit_s1     <= ~warming;
			last_s1     <= last0;
			brd_s1      <= brd0;
			row_s1      <= out_row_q;
			col_s1      <= out_col_q;
			fwd_s1      <= s1_valid_q && (c0 == c_s1);
			fwd_data_s1 <= wdata;
		end
	end

	// line memory: upper half is the older row, lower half the newer
	logic [2*P-1:0]              line_mem [lmax3_pkg::MAX_WIDTH];
	logic [lmax3_pkg::MAX_WIDTH-1:0] line_vld_q;

	always_ff @(posedge clk) begin
		if (acc)
			rdata_s1 <= line_mem[c0];
		if (s1_valid_q)
			line_mem[c_s1] <= wdata;
	end

	// per-column written marks, unwritten entries read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_vld_q <= '0;
			vld_s1     <= 1'b0;
		end else begin
			if (acc)
				vld_s1 <= line_vld_q[c0];
			if (s1_valid_q)
				line_vld_q[c_s1] <= 1'b1;
		end
	end

	// column entering the window, with forwarding of the previous write
	logic [2*P-1:0]      old_word;
	logic signed [P-1:0] col_top, col_mid;

	always_comb begin
		if (fwd_s1)
			old_word = fwd_data_s1;
		else if (vld_s1)
			old_word = rdata_s1;
		else
			old_word = '0;
		col_top = old_word[2*P-1:P];
		col_mid = old_word[P-1:0];
		wdata   = {col_mid, v_s1};
	end

	// 3x3 window shift register
	logic signed [P-1:0] win_q [3][3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < 3; r++)
				for (int k = 0; k < 3; k++)
					win_q[r][k] <= '0;
		end else if (s1_valid_q) begin
			for (int r = 0; r < 3; r++) begin
				win_q[r][0] <= win_q[r][1];
				win_q[r][1] <= win_q[r][2];
			end
			win_q[0][2] <= col_top;
			win_q[1][2] <= col_mid;
			win_q[2][2] <= v_s1;
		end
	end

	// eight parallel compares against the center after the shift
	logic signed [P-1:0] centre;
	logic signed [P-1:0] nb [8];
	logic [7:0]          ign, lt;
	logic                is_max;

	always_comb begin
		centre = win_q[1][2];
		nb[0]  = win_q[0][1];
		nb[1]  = win_q[0][2];
		nb[2]  = col_top;
		nb[3]  = win_q[1][1];
		nb[4]  = col_mid;
		nb[5]  = win_q[2][1];
		nb[6]  = win_q[2][2];
		nb[7]  = v_s1;
		ign[0] = brd_s1.top | brd_s1.left;
		ign[1] = brd_s1.top;
		ign[2] = brd_s1.top | brd_s1.right;
		ign[3] = brd_s1.left;
		ign[4] = brd_s1.right;
		ign[5] = brd_s1.bot | brd_s1.left;
		ign[6] = brd_s1.bot;
		ign[7] = brd_s1.bot | brd_s1.right;
		for (int k = 0; k < 8; k++)
			lt[k] = nb[k] < centre;
		is_max = &(ign | lt);
	end

	// two-entry output queue
	lmax3_pkg::res_t fifo_q [2];
	lmax3_pkg::res_t res_new;
	logic            wr_ptr_q, rd_ptr_q;
	logic [1:0]      cnt_q;
	logic [2:0]      occ_nxt;

	assign push = s1_valid_q & emit_s1;
	assign pop  = res.valid & res.ready;

	always_comb begin
		res_new.center_value = centre;
		res_new.center_row   = row_s1;
		res_new.center_col   = col_s1;
		res_new.is_local_max = is_max;
		res_new.frame_done   = last_s1;
		occ_nxt   = {1'b0, cnt_q} + {2'b0, push} - {2'b0, pop};
		pix.ready = occ_nxt < 3'd2;
	end

	always_ff @(posedge clk) begin
		if (push)
			fifo_q[wr_ptr_q] <= res_new;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (pop)
				rd_ptr_q <= ~rd_ptr_q;
			cnt_q <= occ_nxt[1:0];
		end
	end

	// output channel
	assign res.valid        = (cnt_q != '0);
	assign res.center_value = fifo_q[rd_ptr_q].center_value;
	assign res.center_row   = fifo_q[rd_ptr_q].center_row;
	assign res.center_col   = fifo_q[rd_ptr_q].center_col;
	assign res.is_local_max = fifo_q[rd_ptr_q].is_local_max;
	assign res.frame_done   = fifo_q[rd_ptr_q].frame_done;

`ifndef SYNTHESIS
	// queue never overfills
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 2'd2)
		else $error("output queue count out of range");

	// a verdict in flight always finds room
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (cnt_q < 2'd2 || pop))
		else $error("verdict pushed into full queue");

	// width one reuses the same column every item, so it must forward
	a_fwd_w1: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && s1_valid_q && eff_w == WB'(1)) |=> fwd_s1)
		else $error("missing forward on same column");

	// the last verdict of a frame restarts all counters
	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && !warming && last0) |=>
			(out_row_q == '0 && out_col_q == '0 && warm_q == '0 && in_col_q == '0))
		else $error("counters not cleared at frame end");
`endif

endmodule

// ----- tb/sv/lmax3_verdict_checker.sv -----
`timescale 1ns / 1ps
// lmax3_verdict_checker: watches the pixel, verdict and register channels of
// local_maximum_3x3_top, predicts every verdict and compares it field by field
// depends on lmax3_pkg, lmax3_in_if, lmax3_out_if
module lmax3_verdict_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	lmax3_in_if                             pix,
	lmax3_out_if                            res,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic                            pready,
	input  logic [lmax3_pkg::ADDR_BITS-1:0] paddr,
	input  logic [lmax3_pkg::DATA_BITS-1:0] pwdata,
	output int                              mismatches,
	output int                              outstanding
);
	import lmax3_pkg::*;

	// shadow registers and predicted datapath state
	logic [CFG_BITS-1:0]          width_reg;
	logic [CFG_BITS-1:0]          height_reg;
	logic signed [PIXEL_BITS-1:0] line_mem [2][MAX_WIDTH];
	logic signed [PIXEL_BITS-1:0] win [3][3];
	int unsigned                  in_col;
	int unsigned                  out_col;
	int unsigned                  out_row;
	int unsigned                  warm_count;
	res_t                         expected_verdicts [$];
	res_t                         want;

	// zero falls back to one, anything above the limit to the limit
	function automatic int unsigned clamp_dim(logic [CFG_BITS-1:0] raw, int unsigned limit);
		if (raw == 0)
			return 1;
		if (raw > limit)
			return limit;
		return raw;
	endfunction

	function automatic void restart_frame();
		in_col = 0;
		out_col = 0;
		out_row = 0;
		warm_count = 0;
	endfunction

	// push one item through the line stores and window, queue its verdict if any
	function automatic void predict_verdict(logic op, logic signed [PIXEL_BITS-1:0] px);
		int unsigned                  w;
		int unsigned                  h;
		int unsigned                  c;
		int                           r;
		int                           dr;
		int                           dc;
		logic signed [PIXEL_BITS-1:0] v;
		logic signed [PIXEL_BITS-1:0] centre;
		logic signed [PIXEL_BITS-1:0] column [3];
		logic                         peak;
		logic                         last;
		res_t                         verdict;
		w = clamp_dim(width_reg, MAX_WIDTH);
		h = clamp_dim(height_reg, MAX_HEIGHT);
		v = (op == OP_FLUSH) ? '0 : px;
		c = (in_col >= w) ? 0 : in_col;
		column[0] = line_mem[1][c];
		column[1] = line_mem[0][c];
		column[2] = v;
		line_mem[1][c] = line_mem[0][c];
		line_mem[0][c] = v;
		for (r = 0; r < 3; r++) begin
			win[r][0] = win[r][1];
			win[r][1] = win[r][2];
			win[r][2] = column[r];
		end
		in_col = (c + 1 >= w) ? 0 : c + 1;

		// the first width+1 items of a frame only fill the window
		if (warm_count < w + 1) begin
			warm_count++;
			return;
		end

		// strict maximum over the neighbours that lie inside the frame
		centre = win[1][1];
		peak = 1'b1;
		for (dr = -1; dr <= 1; dr++) begin
			for (dc = -1; dc <= 1; dc++) begin
				if (dr == 0 && dc == 0)
					continue;
				if (dr < 0 && out_row == 0)
					continue;
				if (dr > 0 && out_row + 1 >= h)
					continue;
				if (dc < 0 && out_col == 0)
					continue;
				if (dc > 0 && out_col + 1 >= w)
					continue;
				if (win[1 + dr][1 + dc] >= centre)
					peak = 1'b0;
			end
		end
		last = (out_row + 1 >= h) && (out_col + 1 >= w);

		verdict.center_value = centre;
		verdict.center_row   = ROW_BITS'(out_row);
		verdict.center_col   = COL_BITS'(out_col);
		verdict.is_local_max = peak;
		verdict.frame_done   = last;
		expected_verdicts.push_back(verdict);

		if (last) begin
			restart_frame();
		end else if (out_col + 1 >= w) begin
			out_col = 0;
			out_row++;
		end else begin
			out_col++;
		end
	endfunction

	function automatic void check_field(string name, logic signed [31:0] exp_val,
		logic signed [31:0] got_val);
		if (got_val !== exp_val) begin
			$error("%s: expected %0d, got %0d", name, exp_val, got_val);
			mismatches++;
		end
	endfunction

	// follow register writes, accepted items and accepted verdicts
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_reg = CFG_BITS'(MAX_WIDTH);
			height_reg = CFG_BITS'(MAX_HEIGHT);
			foreach (line_mem[i, j])
				line_mem[i][j] = '0;
			foreach (win[i, j])
				win[i][j] = '0;
			restart_frame();
			expected_verdicts.delete();
			mismatches = 0;
		end else begin
			// a write takes effect at once and restarts the frame
			if (psel && penable && pwrite && pready) begin
				if (paddr[ADDR_BITS-1] == REG_WIDTH)
					width_reg = pwdata[CFG_BITS-1:0];
				else
					height_reg = pwdata[CFG_BITS-1:0];
				restart_frame();
			end
			if (pix.valid && pix.ready)
				predict_verdict(pix.opcode, pix.pixel);
			if (res.valid && res.ready) begin
				if (expected_verdicts.size() == 0) begin
					$error("unexpected verdict: row %0d col %0d value %0d",
						res.center_row, res.center_col, res.center_value);
					mismatches++;
				end else begin
					want = expected_verdicts.pop_front();
					check_field("center_value", want.center_value, res.center_value);
					check_field("center_row", want.center_row, res.center_row);
					check_field("center_col", want.center_col, res.center_col);
					check_field("is_local_max", want.is_local_max, res.is_local_max);
					check_field("frame_done", want.frame_done, res.frame_done);
				end
			end
		end
		outstanding = expected_verdicts.size();
	end

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// tb: drives frames of random size and content into local_maximum_3x3_top under
// several idle patterns and gives the verdict; checking is in lmax3_verdict_checker
// depends on lmax3_pkg, lmax3_in_if, lmax3_out_if, lmax3_verdict_checker, the block
module tb;
	import lmax3_pkg::*;

	localparam int ITEM_TARGET   = 950;
	localparam int LONG_HOLD     = 300;
	localparam int SETTLE_CYCLES = 8;
	localparam int NO_PAUSE      = -1;

	localparam logic signed [PIXEL_BITS-1:0] PIX_MAX = {1'b0, {(PIXEL_BITS-1){1'b1}}};
	localparam logic signed [PIXEL_BITS-1:0] PIX_MIN = {1'b1, {(PIXEL_BITS-1){1'b0}}};

	typedef enum int {IDLE_NONE, IDLE_SRC, IDLE_SNK, IDLE_BOTH} idle_mode_e;
	typedef enum int {VAL_FULL, VAL_NARROW, VAL_EXTREME} val_style_e;

	logic                 clk;
	logic                 arst_n;
	logic                 psel;
	logic                 penable;
	logic                 pwrite;
	logic [ADDR_BITS-1:0] paddr;
	logic [DATA_BITS-1:0] pwdata;
	logic [DATA_BITS-1:0] prdata;
	logic                 pready;
	int                   mismatches;
	int                   outstanding;
	int                   src_idle_pct;
	int                   snk_stall_pct;
	int                   items_sent;
	bit                   hold_request;

	lmax3_in_if  pix_if ();
	lmax3_out_if res_if ();

	local_maximum_3x3_top u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.pix     (pix_if),
		.res     (res_if),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	lmax3_verdict_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.pix         (pix_if),
		.res         (res_if),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.pready      (pready),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit, far beyond the slowest correct run
	initial begin
		#(5_000_000);
		$display("** local_maximum_3x3_top: FAILED **");
		$finish;
	end

	// verdict receiver: random stalls, plus one long hold-off on request
	initial begin
		res_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				res_if.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end
			res_if.ready <= ($urandom_range(99) >= snk_stall_pct);
		end
	end

	function automatic void set_idle(idle_mode_e mode);
		src_idle_pct = (mode == IDLE_SRC) ? 87 : (mode == IDLE_BOTH) ? 38 : 0;
		snk_stall_pct = (mode == IDLE_SNK) ? 87 : (mode == IDLE_BOTH) ? 38 : 0;
	endfunction

	function automatic logic signed [PIXEL_BITS-1:0] rand_pixel(val_style_e style);
		case (style)
			VAL_NARROW: return PIXEL_BITS'($urandom_range(0, 4) - 2);
			VAL_EXTREME: begin
				if ($urandom_range(1))
					return PIXEL_BITS'(PIX_MAX - $urandom_range(0, 1));
				return PIXEL_BITS'(PIX_MIN + $urandom_range(0, 1));
			end
			default: return PIXEL_BITS'($urandom());
		endcase
	endfunction

	// offer one item after a random gap and hold it until accepted
	task automatic send_item(logic op, logic signed [PIXEL_BITS-1:0] px);
		if ($urandom_range(99) < src_idle_pct) begin
			pix_if.valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < src_idle_pct)
				@(posedge clk);
		end
		pix_if.valid <= 1'b1;
		pix_if.opcode <= op;
		pix_if.pixel <= px;
		@(posedge clk);
		while (!pix_if.ready)
			@(posedge clk);
		items_sent++;
	endtask

	task automatic wait_drained();
		pix_if.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	// all verdicts in and the pipeline empty
	task automatic settle();
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic index, logic [CFG_BITS-1:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {index, {(ADDR_BITS-1){1'b0}}};
		pwdata <= {(DATA_BITS-CFG_BITS)'($urandom()), val};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic configure(logic [CFG_BITS-1:0] w_raw, logic [CFG_BITS-1:0] h_raw);
		if ($urandom_range(1)) begin
			write_reg(REG_WIDTH, w_raw);
			write_reg(REG_HEIGHT, h_raw);
		end else begin
			write_reg(REG_HEIGHT, h_raw);
			write_reg(REG_WIDTH, w_raw);
		end
	endtask

	// frame pixels (a few flush items mixed in) then the trailing drain items
	task automatic send_frame(int unsigned n_pix, int unsigned n_tail, int pause_at);
		val_style_e style;
		int         i;
		style = val_style_e'($urandom_range(2));
		for (i = 0; i < n_pix; i++) begin
			if (i == pause_at)
				wait_drained();
			send_item(($urandom_range(24) == 0) ? OP_FLUSH : OP_PIXEL, rand_pixel(style));
		end
		for (i = 0; i < n_tail; i++)
			send_item(($urandom_range(5) == 0) ? OP_PIXEL : OP_FLUSH, rand_pixel(style));
	endtask

	initial begin
		logic signed [PIXEL_BITS-1:0] peak_frame [9];
		logic [CFG_BITS-1:0]          w_raw;
		logic [CFG_BITS-1:0]          h_raw;
		int unsigned                  w;
		int unsigned                  h;
		int unsigned                  n_pix;
		int unsigned                  n_tail;
		int                           phase;
		int                           f;
		int                           n_frames;
		int                           i;

		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		pix_if.valid <= 1'b0;
		pix_if.opcode <= OP_PIXEL;
		pix_if.pixel <= '0;
		set_idle(IDLE_NONE);
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// strict peak in the middle, ties at a corner, full-scale values
		peak_frame = '{PIX_MIN, 5, PIX_MIN, 5, PIX_MAX, 5, PIX_MIN, 5, 5};
		configure(3, 3);
		for (i = 0; i < 9; i++)
			send_item(OP_PIXEL, peak_frame[i]);
		repeat (3) send_item(OP_FLUSH, PIX_MAX);
		// a pixel past the frame end drains like a flush item
		send_item(OP_PIXEL, PIX_MAX);
		// next frame back to back; a flush item inside it counts as zero
		for (i = 0; i < 9; i++)
			send_item((i == 4) ? OP_FLUSH : OP_PIXEL, (i == 4) ? PIX_MIN : -1);
		repeat (4) send_item(OP_FLUSH, '0);
		settle();
		// zero width and height fall back to a single pixel with no neighbours
		configure(0, 0);
		send_item(OP_PIXEL, PIX_MIN);
		repeat (2) send_item(OP_FLUSH, PIX_MIN);

		// widest and tallest frames, oversized register values clamp
		settle();
		set_idle(IDLE_SRC);
		configure(8'd255, 8'd1);
		send_frame(MAX_WIDTH, MAX_WIDTH + 1, NO_PAUSE);
		settle();
		set_idle(IDLE_SNK);
		configure(8'd1, 8'd255);
		send_frame(MAX_HEIGHT, 2, NO_PAUSE);

		// random small frames under rotating idle patterns
		phase = 0;
		while (items_sent < ITEM_TARGET) begin
			settle();
			set_idle(idle_mode_e'(phase % 4));
			w_raw = ($urandom_range(9) == 0) ? '0 : CFG_BITS'($urandom_range(1, 10));
			h_raw = ($urandom_range(9) == 0) ? '0 : CFG_BITS'($urandom_range(1, 10));
			if (phase % 5 == 1) begin
				// receiver holds off while the sender keeps pushing
				set_idle(IDLE_NONE);
				w_raw = CFG_BITS'($urandom_range(4, 10));
				h_raw = CFG_BITS'($urandom_range(4, 10));
				hold_request = 1'b1;
			end
			configure(w_raw, h_raw);
			w = (w_raw == 0) ? 1 : w_raw;
			h = (h_raw == 0) ? 1 : h_raw;
			n_frames = $urandom_range(1, 3);
			for (f = 0; f < n_frames; f++) begin
				n_pix = w * h;
				n_tail = w + 1;
				if ($urandom_range(5) == 0)
					n_tail = $urandom_range(0, w + 3);
				// now and then cut the last frame short; the next write restarts
				if (f == n_frames - 1 && $urandom_range(7) == 0) begin
					n_pix = $urandom_range(1, w * h);
					n_tail = 0;
				end
				send_frame(n_pix, n_tail, (phase % 5 == 3 && f == 0) ? int'(n_pix / 2) : NO_PAUSE);
			end
			phase++;
		end

		settle();
		if (mismatches == 0) begin
			$display("** local_maximum_3x3_top: PASSED **");
		end else begin
			$display("** local_maximum_3x3_top: FAILED **");
		end
		$finish;
	end

endmodule
